// File: src/assert_macros.svh
// Assertion macros shared by the RTL files; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: src/dbt_pkg.sv
// Package: shared types and constants of the debounced button / tap tempo block.
`default_nettype none

package dbt_pkg;

    typedef enum logic [1:0] {
        MODE_OFF       = 2'd0,
        MODE_TOGGLE    = 2'd1,
        MODE_MOMENTARY = 2'd2,
        MODE_TAP       = 2'd3
    } t_mode;

    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_INVERT    = 2'd1;
    localparam logic [1:0] REG_TEMPO_MIN = 2'd2;
    localparam logic [1:0] REG_TEMPO_MAX = 2'd3;

    localparam logic [15:0] TEMPO_MIN_RESET = 16'd100;
    localparam logic [15:0] TEMPO_MAX_RESET = 16'd2000;

    // tap tempo phases; toggle mode keeps the stable level in the same register
    localparam logic [2:0] PH_WAIT   = 3'd0;
    localparam logic [2:0] PH_FIRST  = 3'd1;
    localparam logic [2:0] PH_GAP    = 3'd2;
    localparam logic [2:0] PH_SECOND = 3'd3;
    localparam logic [2:0] PH_HOLD   = 3'd4;

    localparam logic [3:0] DEBOUNCE_LIMIT = 4'd9;
    localparam logic [3:0] STABLE_LIMIT   = 4'd10;
    localparam logic [3:0] COUNT_MAX      = 4'd15;
    localparam logic [15:0] BLINK_ON_TICKS = 16'd10;

    typedef struct packed {
        t_mode       mode;
        logic        invert;
        logic [15:0] tempo_min;
        logic [15:0] tempo_max;
    } t_cfg;

    typedef struct packed {
        logic        press_evt;
        logic        release_evt;
        logic        change_evt;
        logic [15:0] value;
        logic        led_on_evt;
        logic        blink_evt;
        logic [15:0] off_ticks;
    } t_result;

endpackage

`default_nettype wire

// File: src/dbt_cfg.sv
// Configuration register file of the debounced button / tap tempo block.
`default_nettype none

module dbt_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output dbt_pkg::t_cfg      o_cfg
);
    import dbt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_OFF;
            r_cfg.invert    <= 1'b0;
            r_cfg.tempo_min <= TEMPO_MIN_RESET;
            r_cfg.tempo_max <= TEMPO_MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MODE:      r_cfg.mode      <= t_mode'(i_cfg_data[1:0]);
                REG_INVERT:    r_cfg.invert    <= i_cfg_data[0];
                REG_TEMPO_MIN: r_cfg.tempo_min <= i_cfg_data;
                REG_TEMPO_MAX: r_cfg.tempo_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: src/dbt_core.sv
// Button state and the single-tick update for toggle, momentary and tap tempo modes.
`default_nettype none

module dbt_core #(
    parameter int TEMPO_WIDTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_pin_level,
    input  wire dbt_pkg::t_cfg i_cfg,
    output dbt_pkg::t_result   o_res
);
    import dbt_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = ((TEMPO_WIDTH > 16) ? TEMPO_WIDTH : 16) + 1;
    localparam logic [CW-1:0] TEMPO_MASK = CW'({TEMPO_WIDTH{1'b1}});
    localparam logic [CW-1:0] VALUE_MAX  = CW'(16'hFFFF);
    localparam logic [CW-1:0] BLINK_ON   = CW'(BLINK_ON_TICKS);

    logic [2:0]             r_phase, n_phase;
    logic [3:0]             r_stable, n_stable;
    logic [TEMPO_WIDTH-1:0] r_tempo, n_tempo;
    logic [15:0]            r_value, n_value;

    logic                   lvl;
    logic [3:0]             cnt_inc;
    logic [TEMPO_WIDTH:0]   next_t;
    logic [CW-1:0]          next_ext;
    logic [CW-1:0]          iv;
    logic                   expired;
    logic [TEMPO_WIDTH-1:0] tempo_sat;
    t_result                res;

    function automatic logic [15:0] blink_off(input logic [CW-1:0] period);
        logic [CW-1:0] d;
        d = period - BLINK_ON;
        if (period <= BLINK_ON) begin
            return 16'd0;
        end
        return (d > VALUE_MAX) ? 16'hFFFF : d[15:0];
    endfunction

    always_comb begin
        lvl       = ~i_pin_level ^ i_cfg.invert;
        cnt_inc   = (r_stable == COUNT_MAX) ? COUNT_MAX : r_stable + 4'd1;
        next_t    = {1'b0, r_tempo} + {{TEMPO_WIDTH{1'b0}}, 1'b1};
        next_ext  = CW'(next_t);
        expired   = next_ext > CW'(i_cfg.tempo_max);
        tempo_sat = next_t[TEMPO_WIDTH] ? {TEMPO_WIDTH{1'b1}} : next_t[TEMPO_WIDTH-1:0];
        iv        = (next_ext < CW'(i_cfg.tempo_min)) ? CW'(i_cfg.tempo_min) : next_ext;

        n_phase  = r_phase;
        n_stable = r_stable;
        n_tempo  = r_tempo;
        n_value  = r_value;
        res      = '0;

        case (i_cfg.mode)
            MODE_TOGGLE: begin
                if ({2'b00, lvl} != r_phase) begin
                    n_stable = cnt_inc;
                    if (cnt_inc > DEBOUNCE_LIMIT) begin
                        n_phase  = {2'b00, lvl};
                        n_stable = 4'd0;
                        if (lvl) begin
                            res.press_evt  = 1'b1;
                            res.change_evt = 1'b1;
                            n_value = (r_value == 16'd1) ? 16'd0 : 16'd1;
                        end else begin
                            res.release_evt = 1'b1;
                        end
                    end
                end else begin
                    n_stable = 4'd0;
                end
            end
            MODE_MOMENTARY: begin
                if ({15'd0, lvl} != r_value) begin
                    n_stable = cnt_inc;
                    if (cnt_inc > DEBOUNCE_LIMIT) begin
                        n_stable        = 4'd0;
                        res.press_evt   = lvl;
                        res.release_evt = ~lvl;
                        res.change_evt  = 1'b1;
                        n_value         = {15'd0, lvl};
                    end
                end else begin
                    n_stable = 4'd0;
                end
            end
            MODE_TAP: begin
                case (r_phase)
                    PH_WAIT: begin
                        if (lvl) begin
                            n_phase        = PH_FIRST;
                            n_tempo        = '0;
                            res.led_on_evt = 1'b1;
                        end
                    end
                    PH_FIRST, PH_GAP, PH_SECOND: begin
                        n_tempo = tempo_sat;
                        if (expired) begin
                            res.blink_evt = 1'b1;
                            res.off_ticks = blink_off(CW'(r_value));
                            n_phase       = PH_WAIT;
                        end else if (r_phase == PH_FIRST) begin
                            if (!lvl) begin
                                n_phase  = PH_GAP;
                                n_stable = 4'd0;
                            end
                        end else if (r_phase == PH_GAP) begin
                            if (!lvl) begin
                                n_stable = cnt_inc;
                                if (cnt_inc > STABLE_LIMIT) begin
                                    n_phase = PH_SECOND;
                                end
                            end else begin
                                n_stable = 4'd0;
                            end
                        end else if (lvl) begin
                            n_tempo = (iv > TEMPO_MASK) ? {TEMPO_WIDTH{1'b1}}
                                                        : iv[TEMPO_WIDTH-1:0];
                            res.blink_evt  = 1'b1;
                            res.off_ticks  = blink_off(iv);
                            n_value        = (iv > VALUE_MAX) ? 16'hFFFF : iv[15:0];
                            res.change_evt = 1'b1;
                            n_stable       = 4'd0;
                            n_phase        = PH_HOLD;
                        end
                    end
                    PH_HOLD: begin
                        if (!lvl) begin
                            n_stable = cnt_inc;
                            if (cnt_inc > STABLE_LIMIT) begin
                                n_phase = PH_WAIT;
                            end
                        end else begin
                            n_stable = 4'd0;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
            default: begin
            end
        endcase

        res.value = n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_stable <= 4'd0;
            r_tempo  <= '0;
            r_value  <= 16'd0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_stable <= n_stable;
            r_tempo  <= n_tempo;
            r_value  <= n_value;
        end
    end

    assign o_res = res;

    `ASSERT_PROP(a_hold_without_step, i_clk, i_rst_n,
        !i_step |=> ($stable(r_phase) && $stable(r_value) && $stable(r_tempo)),
        "state changed without an item")
    `ASSERT_PROP(a_led_on_starts_timing, i_clk, i_rst_n,
        (i_step && res.led_on_evt) |=> (r_phase == PH_FIRST && r_tempo == '0),
        "first tap did not start the interval timer")
    `ASSERT_PROP(a_off_mode_quiet, i_clk, i_rst_n,
        (i_step && i_cfg.mode == MODE_OFF) |=> ($stable(r_phase) && $stable(r_stable)),
        "disabled mode changed the state")
    `ASSERT_NEVER(a_off_needs_blink, i_clk, i_rst_n,
        (!res.blink_evt && res.off_ticks != 16'd0),
        "blink off time without a blink request")

endmodule

`default_nettype wire

// File: src/debounced_button_tap_tempo.sv
// Pipeline: an accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle unless stalled; the state update is combinational between registers.
// Backpressure: the input register advances whenever the result register is empty or being taken.
// Reset: synchronous, active low; clears both valids, the state and loads the register defaults.
// No clearing pass; the block takes items as soon as reset is released.
`default_nettype none

module debounced_button_tap_tempo #(
    parameter int TEMPO_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_pin_level,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_press_event,
    output logic             o_release_event,
    output logic             o_change_event,
    output logic [15:0]      o_button_value,
    output logic             o_led_on_event,
    output logic             o_led_blink_event,
    output logic [15:0]      o_blink_off_ticks
);
    import dbt_pkg::*;

    `include "assert_macros.svh"

    t_cfg    cfg;
    t_result res;
    logic    s1_move;

    logic    r_s1_valid;
    logic    r_s1_pin;
    logic    r_out_valid;
    t_result r_out;

    dbt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dbt_core #(
        .TEMPO_WIDTH (TEMPO_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s1_move),
        .i_pin_level (r_s1_pin),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    assign s1_move = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_pin <= i_pin_level;
        end
        if (s1_move) begin
            r_out <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_press_event     = r_out.press_evt;
    assign o_release_event   = r_out.release_evt;
    assign o_change_event    = r_out.change_evt;
    assign o_button_value    = r_out.value;
    assign o_led_on_event    = r_out.led_on_evt;
    assign o_led_blink_event = r_out.blink_evt;
    assign o_blink_off_ticks = r_out.off_ticks;

    `ASSERT_PROP(a_stall_blocks_input, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && !i_ready) |-> !o_ready,
        "input taken while both stages are full and stalled")
    `ASSERT_PROP(a_move_fills_output, i_clk, i_rst_n,
        s1_move |=> o_valid,
        "item left the input register but no result appeared")

endmodule

`default_nettype wire

// File: verif/debounced_button_tap_tempo_tb.sv
// Testbench for debounced_button_tap_tempo: directed table then random button runs vs predictor.
module debounced_button_tap_tempo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 950;
    localparam int CALM_AFTER = 800;
    localparam int LONG_HOLD = 64;

    typedef struct packed {
        logic        is_write;
        logic [1:0]  idx;
        logic [15:0] data;
        logic        pin;
        logic [7:0]  reps;
        logic        typed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_MODE;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_pin_level = 1'b1;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_press_event;
    logic        o_release_event;
    logic        o_change_event;
    logic [15:0] o_button_value;
    logic        o_led_on_event;
    logic        o_led_blink_event;
    logic [15:0] o_blink_off_ticks;

    // predictor configuration and state
    t_mode       cfg_mode = MODE_OFF;
    logic        cfg_inv = 1'b0;
    logic [15:0] cfg_min = TEMPO_MIN_RESET;
    logic [15:0] cfg_max = TEMPO_MAX_RESET;
    logic [2:0]  st_phase = PH_WAIT;
    logic [3:0]  st_stable = '0;
    logic [15:0] st_tempo = '0;
    logic [15:0] st_value = '0;

    t_result pending_results[$];
    int      mismatches = 0;
    int      results_seen = 0;
    bit      calm = 1'b0;

    debounced_button_tap_tempo dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pin_level       (i_pin_level),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_press_event     (o_press_event),
        .o_release_event   (o_release_event),
        .o_change_event    (o_change_event),
        .o_button_value    (o_button_value),
        .o_led_on_event    (o_led_on_event),
        .o_led_blink_event (o_led_blink_event),
        .o_blink_off_ticks (o_blink_off_ticks)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [15:0] off_time(logic [16:0] period);
        logic [16:0] rest;
        if (period <= 17'(BLINK_ON_TICKS)) return '0;
        rest = period - 17'(BLINK_ON_TICKS);
        return rest[16] ? 16'hFFFF : rest[15:0];
    endfunction

    function automatic void bump_stable();
        if (st_stable < COUNT_MAX) st_stable = st_stable + 4'd1;
    endfunction

    // one tick of the button block, updates the predictor state
    function automatic t_result button_step(logic pin);
        logic        lvl;
        logic        expired;
        logic [16:0] nxt;
        logic [16:0] iv;
        t_result     r;
        r = '0;
        lvl = ~pin ^ cfg_inv;
        case (cfg_mode)
            MODE_TOGGLE: begin
                if ({2'b0, lvl} != st_phase) begin
                    bump_stable();
                    if (st_stable > DEBOUNCE_LIMIT) begin
                        st_phase = {2'b0, lvl};
                        st_stable = '0;
                        if (lvl) begin
                            r.press_evt = 1'b1;
                            st_value = (st_value == 16'd1) ? 16'd0 : 16'd1;
                            r.change_evt = 1'b1;
                        end else begin
                            r.release_evt = 1'b1;
                        end
                    end
                end else begin
                    st_stable = '0;
                end
            end
            MODE_MOMENTARY: begin
                if ({15'b0, lvl} != st_value) begin
                    bump_stable();
                    if (st_stable > DEBOUNCE_LIMIT) begin
                        st_stable = '0;
                        if (lvl) r.press_evt = 1'b1;
                        else r.release_evt = 1'b1;
                        st_value = {15'b0, lvl};
                        r.change_evt = 1'b1;
                    end
                end else begin
                    st_stable = '0;
                end
            end
            MODE_TAP: begin
                case (st_phase)
                    PH_WAIT: begin
                        if (lvl) begin
                            st_phase = PH_FIRST;
                            st_tempo = '0;
                            r.led_on_evt = 1'b1;
                        end
                    end
                    PH_FIRST, PH_GAP, PH_SECOND: begin
                        nxt = {1'b0, st_tempo} + 17'd1;
                        expired = nxt > {1'b0, cfg_max};
                        st_tempo = nxt[16] ? 16'hFFFF : nxt[15:0];
                        if (expired) begin
                            r.blink_evt = 1'b1;
                            r.off_ticks = off_time({1'b0, st_value});
                            st_phase = PH_WAIT;
                        end else if (st_phase == PH_FIRST) begin
                            if (!lvl) begin
                                st_phase = PH_GAP;
                                st_stable = '0;
                            end
                        end else if (st_phase == PH_GAP) begin
                            if (!lvl) begin
                                bump_stable();
                                if (st_stable > STABLE_LIMIT) st_phase = PH_SECOND;
                            end else begin
                                st_stable = '0;
                            end
                        end else if (lvl) begin
                            iv = nxt;
                            if (iv < {1'b0, cfg_min}) iv = {1'b0, cfg_min};
                            st_tempo = iv[16] ? 16'hFFFF : iv[15:0];
                            r.blink_evt = 1'b1;
                            r.off_ticks = off_time(iv);
                            st_value = iv[16] ? 16'hFFFF : iv[15:0];
                            r.change_evt = 1'b1;
                            st_stable = '0;
                            st_phase = PH_HOLD;
                        end
                    end
                    PH_HOLD: begin
                        if (!lvl) begin
                            bump_stable();
                            if (st_stable > STABLE_LIMIT) st_phase = PH_WAIT;
                        end else begin
                            st_stable = '0;
                        end
                    end
                    default: st_phase = PH_WAIT;
                endcase
            end
            default: ;
        endcase
        r.value = st_value;
        return r;
    endfunction

    function automatic t_row hold_pin(logic pin, int unsigned n);
        t_row r;
        r = '0;
        r.pin = pin;
        r.reps = 8'(n);
        return r;
    endfunction

    function automatic t_row tick_check(logic pin, t_result want);
        t_row r;
        r = '0;
        r.pin = pin;
        r.reps = 8'd1;
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_row reg_wr(logic [1:0] idx, logic [15:0] data);
        t_row r;
        r = '0;
        r.is_write = 1'b1;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic drive_tick(logic pin, logic typed, t_result want);
        t_result r;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pin_level <= pin;
        do @(posedge i_clk); while (!o_ready);
        r = button_step(pin);
        pending_results.push_back(typed ? want : r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MODE:      cfg_mode = t_mode'(data[1:0]);
            REG_INVERT:    cfg_inv = data[0];
            REG_TEMPO_MIN: cfg_min = data;
            REG_TEMPO_MAX: cfg_max = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no item pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("press_event", want.press_evt, o_press_event);
                check_field("release_event", want.release_evt, o_release_event);
                check_field("change_event", want.change_evt, o_change_event);
                check_field("button_value", want.value, o_button_value);
                check_field("led_on_event", want.led_on_evt, o_led_on_event);
                check_field("led_blink_event", want.blink_evt, o_led_blink_event);
                check_field("blink_off_ticks", want.off_ticks, o_blink_off_ticks);
            end
        end
    end

    // receiver: short random stalls, one long hold-off
    initial begin
        int  stall_left;
        bit  held_long;
        stall_left = 0;
        held_long = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_long && results_seen >= 400) begin
                held_long = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_row        plan[$];
        int          rand_items;
        int          quota;
        int          n;
        int          len;
        int          pick;
        logic        lvl;
        logic [15:0] val;

        plan = '{
            tick_check(1'b1, '0),
            tick_check(1'b0, '0),
            reg_wr(REG_MODE, 16'(MODE_TOGGLE)),
            hold_pin(1'b0, 9),
            tick_check(1'b0, '{press_evt: 1'b1, change_evt: 1'b1, value: 16'd1,
                               default: '0}),
            hold_pin(1'b1, 12),
            hold_pin(1'b0, 4),              // bounce shorter than the debounce
            hold_pin(1'b1, 4),
            reg_wr(REG_INVERT, 16'd1),
            hold_pin(1'b1, 12),
            reg_wr(REG_INVERT, 16'd0),
            reg_wr(REG_MODE, 16'(MODE_MOMENTARY)),
            hold_pin(1'b0, 12),
            hold_pin(1'b1, 12),
            reg_wr(REG_MODE, 16'(MODE_TAP)),
            hold_pin(1'b1, 14),
            // short interval clamps up to the minimum
            tick_check(1'b0, '{change_evt: 1'b1, value: 16'd100, blink_evt: 1'b1,
                               off_ticks: 16'd90, default: '0}),
            hold_pin(1'b1, 12),
            reg_wr(REG_TEMPO_MIN, 16'hFFFF),
            reg_wr(REG_TEMPO_MAX, 16'hFFFF),
            tick_check(1'b0, '{led_on_evt: 1'b1, value: 16'd100, default: '0}),
            hold_pin(1'b1, 12),
            tick_check(1'b0, '{change_evt: 1'b1, value: 16'hFFFF, blink_evt: 1'b1,
                               off_ticks: 16'd65525, default: '0}),
            hold_pin(1'b1, 11),
            reg_wr(REG_TEMPO_MAX, 16'd0),
            tick_check(1'b0, '{led_on_evt: 1'b1, value: 16'hFFFF, default: '0}),
            // expires on the first count
            tick_check(1'b0, '{value: 16'hFFFF, blink_evt: 1'b1, off_ticks: 16'd65525,
                               default: '0}),
            reg_wr(REG_TEMPO_MIN, 16'd0),
            reg_wr(REG_TEMPO_MAX, 16'd20),
            hold_pin(1'b1, 3),
            hold_pin(1'b0, 2),
            hold_pin(1'b1, 12),
            tick_check(1'b0, '{change_evt: 1'b1, value: 16'd14, blink_evt: 1'b1,
                               off_ticks: 16'd4, default: '0}),
            hold_pin(1'b1, 12),
            hold_pin(1'b0, 1),
            hold_pin(1'b1, 25),             // expires while waiting for the second tap
            reg_wr(REG_MODE, 16'(MODE_MOMENTARY)),
            hold_pin(1'b1, 11),             // value wider than one bit
            reg_wr(REG_MODE, 16'(MODE_TAP)),
            hold_pin(1'b0, 1),
            hold_pin(1'b1, 25),             // blink period under the on time
            hold_pin(1'b0, 1),
            hold_pin(1'b1, 12),
            hold_pin(1'b0, 3),              // left in the hold phase
            reg_wr(REG_MODE, 16'(MODE_TOGGLE)),
            hold_pin(1'b0, 12),
            reg_wr(REG_MODE, 16'(MODE_OFF)),
            hold_pin(1'b1, 3)
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                repeat (plan[i].reps) drive_tick(plan[i].pin, plan[i].typed, plan[i].want);
            end
        end

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            drain();
            if (rand_items >= CALM_AFTER) calm = 1'b1;
            write_reg(REG_MODE, 16'($urandom));
            if ($urandom_range(0, 1) == 0) write_reg(REG_INVERT, 16'($urandom));
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) val = 16'hFFFF;
                else if (pick == 1) val = 16'($urandom);
                else val = 16'($urandom_range(0, 120));
                write_reg(REG_TEMPO_MIN, val);
            end
            if ($urandom_range(0, 1) == 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) val = 16'd0;
                else if (pick == 1) val = 16'hFFFF;
                else if (pick == 2) val = 16'($urandom);
                else val = 16'($urandom_range(15, 250));
                write_reg(REG_TEMPO_MAX, val);
            end
            quota = $urandom_range(60, 140);
            n = 0;
            lvl = 1'($urandom_range(0, 1));
            while (n < quota) begin
                pick = $urandom_range(0, 19);
                if (pick < 2) begin
                    len = $urandom_range(1, 8);
                    repeat (len) drive_tick(1'($urandom_range(0, 1)), 1'b0, '0);
                end else begin
                    if (pick < 7) len = $urandom_range(1, 9);
                    else if (pick < 18) len = $urandom_range(10, 40);
                    else len = $urandom_range(40, 120);
                    repeat (len) drive_tick(lvl, 1'b0, '0);
                    lvl = ~lvl;
                end
                n += len;
            end
            rand_items += n;
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
